### rtl/cspc_pkg.sv
// cspc_pkg: shared types, constants and helpers for the colour sensor
// pulse classifier. No dependencies.
`timescale 1ns / 1ps

package cspc_pkg;

  localparam int W = 20;
  localparam int CFG_AW = 2;
  localparam int MINRUN_W = 8;

  localparam logic [W-1:0] MAX_VAL = {W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_MIN_RUN_LENGTH = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_DARK_THRESHOLD = 2'd2;

  localparam logic [W-1:0]        RST_WINDOW_LENGTH  = 20'd1000;
  localparam logic [MINRUN_W-1:0] RST_MIN_RUN_LENGTH = 8'd1;
  localparam logic [W-1:0]        RST_DARK_THRESHOLD = 20'd200;

  // channel indexes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // filter pin codes (s2,s3)
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd3;
  localparam logic [1:0] SEL_BLUE  = 2'd1;

  // colour codes
  localparam logic [1:0] COL_NONE  = 2'd0;
  localparam logic [1:0] COL_RED   = 2'd1;
  localparam logic [1:0] COL_GREEN = 2'd2;
  localparam logic [1:0] COL_BLUE  = 2'd3;

  typedef struct packed {
    logic step;    // sample taken, window stays open
    logic close;   // sample taken, window closes: start dividers
    logic finish;  // store period, clear sums, load result
  } cmd_t;

  typedef struct packed {
    logic close_now;
    logic div_busy;
  } status_t;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W] ? MAX_VAL : s[W-1:0];
  endfunction

  function automatic logic [1:0] select_code(input logic [1:0] ch);
    logic [1:0] r;
    unique case (ch)
      CH_GREEN: r = SEL_GREEN;
      CH_BLUE:  r = SEL_BLUE;
      default:  r = SEL_RED;
    endcase
    return r;
  endfunction

endpackage

### rtl/cspc_divider.sv
// cspc_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on cspc_pkg for the operand width.
`timescale 1ns / 1ps

module cspc_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [cspc_pkg::W-1:0] dividend,
  input  logic [cspc_pkg::W-1:0] divisor,
  output logic                   busy,
  output logic [cspc_pkg::W-1:0] quotient
);

  localparam int W = cspc_pkg::W;
  localparam int CW = $clog2(W);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic [W:0]    shifted;
  logic          ge;

  assign shifted = {rem_r, quo_r[W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    if (ge) begin
      rem_nxt = W'(shifted - {1'b0, dvs_r});
    end else begin
      rem_nxt = shifted[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CW'(W - 1)) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### rtl/cspc_datapath.sv
// cspc_datapath: configuration registers, run/sum counters, two dividers,
// period store, classifier and result registers. Depends on cspc_pkg, cspc_divider.
`timescale 1ns / 1ps

module cspc_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cspc_pkg::cmd_t               cmd,
  output cspc_pkg::status_t            status,
  input  logic                         cfg_wr_en,
  input  logic [cspc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [cspc_pkg::W-1:0]       cfg_wdata,
  input  logic                         in_sample_bit,
  output logic [1:0]                   out_filter_select,
  output logic                         out_color_valid,
  output logic [1:0]                   out_color_code,
  output logic [cspc_pkg::W-1:0]       out_red_period,
  output logic [cspc_pkg::W-1:0]       out_green_period,
  output logic [cspc_pkg::W-1:0]       out_blue_period
);

  localparam int W = cspc_pkg::W;
  localparam logic [W-1:0] ONE = W'(1);

  logic [W-1:0] win_len_r, dark_r;
  logic [cspc_pkg::MINRUN_W-1:0] min_run_r;

  logic [1:0]   chan_r;
  logic [W-1:0] wc_r, hrun_r, lrun_r, hsum_r, hcnt_r, lsum_r, lcnt_r;
  logic [W-1:0] red_r, green_r, blue_r;

  logic [W-1:0] hrun_nxt, lrun_nxt, hsum_nxt, hcnt_nxt, lsum_nxt, lcnt_nxt;
  logic [W-1:0] wc_inc, len;
  logic [W-1:0] min_ext;

  logic         hdiv_busy, ldiv_busy;
  logic [W-1:0] hq, lq, ah, al;
  logic [W:0]   avg_sum;
  logic [W-1:0] mean;
  logic [1:0]   ch;
  logic [W-1:0] r_new, g_new, b_new;
  logic [1:0]   colour;

  logic [1:0]   fsel_r, code_r;
  logic         cval_r;
  logic [W-1:0] rp_r, gp_r, bp_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= cspc_pkg::RST_WINDOW_LENGTH;
      min_run_r <= cspc_pkg::RST_MIN_RUN_LENGTH;
      dark_r    <= cspc_pkg::RST_DARK_THRESHOLD;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        cspc_pkg::CFG_WINDOW_LENGTH:  win_len_r <= cfg_wdata;
        cspc_pkg::CFG_MIN_RUN_LENGTH: min_run_r <= cfg_wdata[cspc_pkg::MINRUN_W-1:0];
        cspc_pkg::CFG_DARK_THRESHOLD: dark_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign min_ext = {{(W - cspc_pkg::MINRUN_W){1'b0}}, min_run_r};
  assign len     = (win_len_r == '0) ? ONE : win_len_r;
  assign wc_inc  = cspc_pkg::sat_add(wc_r, ONE);

  // run tracking: on a level change the run that just ended is banked if longer than the minimum run
  always_comb begin
    hrun_nxt = hrun_r;
    lrun_nxt = lrun_r;
    hsum_nxt = hsum_r;
    hcnt_nxt = hcnt_r;
    lsum_nxt = lsum_r;
    lcnt_nxt = lcnt_r;
    if (in_sample_bit) begin
      if (lrun_r > min_ext) begin
        lsum_nxt = cspc_pkg::sat_add(lsum_r, lrun_r);
        lcnt_nxt = cspc_pkg::sat_add(lcnt_r, ONE);
      end
      lrun_nxt = '0;
      hrun_nxt = cspc_pkg::sat_add(hrun_r, ONE);
    end else begin
      if (hrun_r > min_ext) begin
        hsum_nxt = cspc_pkg::sat_add(hsum_r, hrun_r);
        hcnt_nxt = cspc_pkg::sat_add(hcnt_r, ONE);
      end
      hrun_nxt = '0;
      lrun_nxt = cspc_pkg::sat_add(lrun_r, ONE);
    end
  end

  cspc_divider u_hdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.close),
    .dividend (hsum_nxt),
    .divisor  ((hcnt_nxt == '0) ? ONE : hcnt_nxt),
    .busy     (hdiv_busy),
    .quotient (hq)
  );

  cspc_divider u_ldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.close),
    .dividend (lsum_nxt),
    .divisor  ((lcnt_nxt == '0) ? ONE : lcnt_nxt),
    .busy     (ldiv_busy),
    .quotient (lq)
  );

  // zero pulse count reads as full scale
  assign ah      = (hcnt_r == '0) ? cspc_pkg::MAX_VAL : hq;
  assign al      = (lcnt_r == '0) ? cspc_pkg::MAX_VAL : lq;
  assign avg_sum = {1'b0, ah} + {1'b0, al};
  assign mean    = avg_sum[W:1];

  assign ch    = (chan_r > cspc_pkg::CH_BLUE) ? cspc_pkg::CH_RED : chan_r;
  assign r_new = (ch == cspc_pkg::CH_RED)   ? mean : red_r;
  assign g_new = (ch == cspc_pkg::CH_GREEN) ? mean : green_r;
  assign b_new = (ch == cspc_pkg::CH_BLUE)  ? mean : blue_r;

  always_comb begin
    if (r_new > dark_r && g_new > dark_r && b_new > dark_r) begin
      colour = cspc_pkg::COL_NONE;
    end else if (r_new < g_new) begin
      colour = (r_new < b_new) ? cspc_pkg::COL_RED : cspc_pkg::COL_BLUE;
    end else begin
      colour = (g_new < b_new) ? cspc_pkg::COL_GREEN : cspc_pkg::COL_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r  <= cspc_pkg::CH_RED;
      wc_r    <= '0;
      hrun_r  <= '0;
      lrun_r  <= '0;
      hsum_r  <= '0;
      hcnt_r  <= '0;
      lsum_r  <= '0;
      lcnt_r  <= '0;
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
    end else begin
      if (cmd.step || cmd.close) begin
        hrun_r <= hrun_nxt;
        lrun_r <= lrun_nxt;
        hsum_r <= hsum_nxt;
        hcnt_r <= hcnt_nxt;
        lsum_r <= lsum_nxt;
        lcnt_r <= lcnt_nxt;
        wc_r   <= cmd.close ? '0 : wc_inc;
      end
      if (cmd.finish) begin
        red_r   <= r_new;
        green_r <= g_new;
        blue_r  <= b_new;
        hsum_r  <= '0;
        hcnt_r  <= '0;
        lsum_r  <= '0;
        lcnt_r  <= '0;
        chan_r  <= (ch == cspc_pkg::CH_BLUE) ? cspc_pkg::CH_RED : ch + 2'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      fsel_r <= cspc_pkg::select_code(chan_r);
      cval_r <= 1'b0;
      code_r <= cspc_pkg::COL_NONE;
      rp_r   <= red_r;
      gp_r   <= green_r;
      bp_r   <= blue_r;
    end else if (cmd.finish) begin
      fsel_r <= cspc_pkg::select_code((ch == cspc_pkg::CH_BLUE) ? cspc_pkg::CH_RED
                                                               : ch + 2'd1);
      cval_r <= (ch == cspc_pkg::CH_BLUE);
      code_r <= (ch == cspc_pkg::CH_BLUE) ? colour : cspc_pkg::COL_NONE;
      rp_r   <= r_new;
      gp_r   <= g_new;
      bp_r   <= b_new;
    end
  end

  assign status.close_now = (wc_inc >= len);
  assign status.div_busy  = hdiv_busy | ldiv_busy;

  assign out_filter_select = fsel_r;
  assign out_color_valid   = cval_r;
  assign out_color_code    = code_r;
  assign out_red_period    = rp_r;
  assign out_green_period  = gp_r;
  assign out_blue_period   = bp_r;

endmodule

### rtl/cspc_ctrl.sv
// cspc_ctrl: sequencing state machine and result valid flag.
// Depends on cspc_pkg for the command and status structs.
`timescale 1ns / 1ps

module cspc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cspc_pkg::status_t status,
  output cspc_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free, accept;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  assign cmd.step   = accept && !status.close_now;
  assign cmd.close  = accept && status.close_now;
  assign cmd.finish = (state_r == S_FIN) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (cmd.close) state_nxt = S_DIV;
      S_DIV:   if (!status.div_busy) state_nxt = S_FIN;
      S_FIN:   if (cmd.finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.step || cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.step, cmd.close, cmd.finish}))
    else $error("more than one datapath command at once");

  a_close_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.close |=> (state_r == S_DIV) && status.div_busy)
    else $error("dividers not running after window close");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("sample accepted during period computation");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !status.div_busy)
    else $error("result loaded while dividers busy");

endmodule

### rtl/color_sensor_pulse_classifier_unit.sv
// color_sensor_pulse_classifier_unit: top level of the pulse classifier.
// Depends on cspc_pkg, cspc_ctrl, cspc_datapath (and cspc_divider below it).
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------
//  in      | in_sample_bit                           | in_valid/in_ready
//  out     | out_filter_select .. out_blue_period    | out_valid/out_ready
//  cfg     | cfg_addr, cfg_wdata                     | cfg_wr_en, no wait
//
// A sample that leaves the window open is taken at one per clock unless
// the result register is full. A sample that closes a window starts two
// 20-bit dividers side by side at one quotient bit per cycle, then the
// period is stored; input is held off until then. Synchronous active-low
// reset; no clearing pass.
`timescale 1ns / 1ps

module color_sensor_pulse_classifier_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_sample_bit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_filter_select,
  output logic                        out_color_valid,
  output logic [1:0]                  out_color_code,
  output logic [cspc_pkg::W-1:0]      out_red_period,
  output logic [cspc_pkg::W-1:0]      out_green_period,
  output logic [cspc_pkg::W-1:0]      out_blue_period,
  input  logic                        cfg_wr_en,
  input  logic [cspc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [cspc_pkg::W-1:0]      cfg_wdata
);

  cspc_pkg::cmd_t    cmd;
  cspc_pkg::status_t status;

  cspc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cspc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_sample_bit     (in_sample_bit),
    .out_filter_select (out_filter_select),
    .out_color_valid   (out_color_valid),
    .out_color_code    (out_color_code),
    .out_red_period    (out_red_period),
    .out_green_period  (out_green_period),
    .out_blue_period   (out_blue_period)
  );

endmodule
